/* design/linear_to_srgb_tonemap_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the linear to sRGB tonemap block
// Each macro expects clk_i and rst_ni in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef LINEAR_TO_SRGB_TONEMAP_MACROS_SVH
`define LINEAR_TO_SRGB_TONEMAP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define LSRGB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define LSRGB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/lsrgb_pkg.sv */
// ----------------------------------------------------------------------------
// lsrgb_pkg
// Shared constants, stage-advance type and curve table builder for the tonemap.
// ----------------------------------------------------------------------------
package lsrgb_pkg;

  localparam int CurveTableBits = 10;
  localparam int CurvePoints    = (1 << CurveTableBits) + 1;
  localparam int FracBits       = 24 - CurveTableBits;
  localparam int CurveWidth     = 26;

  localparam int LinWidth   = 32;
  localparam int ScaleWidth = 24;
  localparam int ProdWidth  = LinWidth + ScaleWidth;

  localparam logic [ScaleWidth-1:0] ScaleReset   = 24'd8388608;
  localparam logic [23:0]           LinearLimit  = 24'd52526;
  localparam logic [18:0]           LinearSlope  = 19'd330752;  // 12.92 * 256 * 100
  localparam logic [12:0]           DivHundredMul = 13'd5243;   // 2^19 / 100, rounded up
  localparam logic [7:0]            ByteMax      = 8'd255;

  typedef logic signed [CurveWidth-1:0] curve_tab_t [CurvePoints];

  // Per-stage advance enables, stage 1 at the input side.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } lsrgb_adv_t;

  function automatic logic [63:0] mul_q30(input logic [63:0] a, input logic [63:0] b);
    return (a * b + (64'd1 << 29)) >> 30;
  endfunction

  function automatic logic [63:0] pow12_q30(input logic [63:0] r);
    logic [63:0] s2;
    logic [63:0] s4;
    logic [63:0] s8;
    s2 = mul_q30(r, r);
    s4 = mul_q30(s2, s2);
    s8 = mul_q30(s4, s4);
    return mul_q30(s8, s4);
  endfunction

  // (k / 2^CurveTableBits)^(5/12) in Q30, by bisection on a twelfth root.
  function automatic logic [63:0] curve_root_q30(input int unsigned k);
    logic [63:0] m;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    logic [63:0] r;
    logic [63:0] r2;
    logic [63:0] y;
    int unsigned e;
    if (k == 0) begin
      return 64'd0;
    end
    m = 64'(k) << (30 - CurveTableBits);
    e = 0;
    for (int i = 0; i < 8; i++) begin
      if (m < (64'd1 << 18)) begin
        m = m << 12;
        e++;
      end
    end
    lo = 64'd1 << 29;
    hi = 64'd1 << 30;
    if (pow12_q30(hi) <= m) begin
      r = hi;
    end else begin
      for (int j = 0; j < 40; j++) begin
        if (hi - lo > 64'd1) begin
          mid = (lo + hi) >> 1;
          if (pow12_q30(mid) <= m) lo = mid;
          else hi = mid;
        end
      end
      r = lo;
    end
    r2 = mul_q30(r, r);
    y  = mul_q30(mul_q30(r2, r2), r);
    if (5 * e >= 64) begin
      return 64'd0;
    end
    return y >> (5 * e);
  endfunction

  // Table entries: 256 * (1.055*y - 0.055) in signed Q16, rounded.
  function automatic curve_tab_t build_curve();
    curve_tab_t      tab;
    logic [63:0]     t;
    logic signed [63:0] ts;
    for (int k = 0; k < CurvePoints; k++) begin
      t  = (64'd1055 * curve_root_q30(k) + 64'd32000) / 64'd64000;
      ts = $signed(t) - 64'sd922747;
      tab[k] = ts[CurveWidth-1:0];
    end
    return tab;
  endfunction

endpackage

/* design/linear_to_srgb_tonemap.sv */
// ----------------------------------------------------------------------------
// linear_to_srgb_tonemap
// Pixel pipeline: scale accumulated linear RGB, sRGB-encode, emit three bytes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid_i/in_ready_o carries one pixel item: three unsigned
//   Q16.16 linear sums. Output channel out_valid_o/out_ready_i carries the
//   three sRGB bytes of that pixel, in arrival order.
//   pass_scale_i is written when pass_scale_we_i is high (Q1.23, normally
//   round(2^23/passes)); write it only while the pipeline is empty.
//   Each accepted pixel passes four registered stages on its way to out_valid_o
//   (multiply, curve table read, interpolation multiply, add and clamp in the
//   output register). Throughput: one pixel per cycle while out_ready_i is high,
//   with each per-channel curve table read at two addresses in the same cycle.
//   Reset empties the pipeline and loads a scale of 1.0.
//   When the receiver stalls, the output register holds its item and each
//   stage holds only if the stage after it is occupied, so bubbles still
//   close up and input stays open until every stage is full.
// ----------------------------------------------------------------------------
module linear_to_srgb_tonemap
  import lsrgb_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  pass_scale_we_i,
  input  logic [ScaleWidth-1:0] pass_scale_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [LinWidth-1:0]   red_linear_i,
  input  logic [LinWidth-1:0]   green_linear_i,
  input  logic [LinWidth-1:0]   blue_linear_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [7:0]            red_byte_o,
  output logic [7:0]            green_byte_o,
  output logic [7:0]            blue_byte_o
);

  logic [ScaleWidth-1:0] scale_q;
  logic [3:0]            valid_q;   // bit 0 is stage 1, bit 3 the output register
  lsrgb_adv_t            adv;

  // Advance a stage when it is empty or the next stage moves on.
  assign adv.s4 = !valid_q[3] || out_ready_i;
  assign adv.s3 = !valid_q[2] || adv.s4;
  assign adv.s2 = !valid_q[1] || adv.s3;
  assign adv.s1 = !valid_q[0] || adv.s2;

  assign in_ready_o  = adv.s1;
  assign out_valid_o = valid_q[3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= ScaleReset;
      valid_q <= '0;
    end else begin
      if (pass_scale_we_i) begin
        scale_q <= pass_scale_i;
      end
      if (adv.s1) valid_q[0] <= in_valid_i;
      if (adv.s2) valid_q[1] <= valid_q[0];
      if (adv.s3) valid_q[2] <= valid_q[1];
      if (adv.s4) valid_q[3] <= valid_q[2];
    end
  end

  // One datapath per colour; all share the stage enables.
  lsrgb_channel u_red (
    .clk_i   (clk_i),
    .adv_i   (adv),
    .lin_i   (red_linear_i),
    .scale_i (scale_q),
    .byte_o  (red_byte_o)
  );

  lsrgb_channel u_green (
    .clk_i   (clk_i),
    .adv_i   (adv),
    .lin_i   (green_linear_i),
    .scale_i (scale_q),
    .byte_o  (green_byte_o)
  );

  lsrgb_channel u_blue (
    .clk_i   (clk_i),
    .adv_i   (adv),
    .lin_i   (blue_linear_i),
    .scale_i (scale_q),
    .byte_o  (blue_byte_o)
  );

  `include "linear_to_srgb_tonemap_macros.svh"

  // Input closes only when every stage holds an item.
  `LSRGB_ASSERT_NOW(a_full_when_blocked, !in_ready_o, (&valid_q) && out_valid_o, "input blocked with a free stage")
  // An item in stage 1 that advances reaches stage 2.
  `LSRGB_ASSERT_NEXT(a_item_moves, valid_q[0] && adv.s2, valid_q[1], "item dropped between stages 1 and 2")
  // A stalled stage-3 item stays in place.
  `LSRGB_ASSERT_NEXT(a_stall_keeps, valid_q[2] && !adv.s3, valid_q[2], "item lost in stalled stage 3")

endmodule

/* design/lsrgb_channel.sv */
// ----------------------------------------------------------------------------
// lsrgb_channel
// Four-stage datapath for one colour: scale, curve lookup, interpolate, clamp.
// ----------------------------------------------------------------------------
module lsrgb_channel
  import lsrgb_pkg::*;
(
  input  logic                  clk_i,
  input  lsrgb_adv_t            adv_i,
  input  logic [LinWidth-1:0]   lin_i,
  input  logic [ScaleWidth-1:0] scale_i,
  output logic [7:0]            byte_o
);

  localparam curve_tab_t CurveTab = build_curve();

  // Stage 1: scaled product
  logic [ProdWidth-1:0] prod_q;

  // Stage 2: table pair, fraction, linear-segment product
  logic signed [CurveWidth-1:0] lo_q, hi_q;
  logic [FracBits-1:0]          frac_q;
  logic [34:0]                  linprod_q;
  logic                         sat2_q, lseg2_q;

  // Stage 3: interpolation product, base, linear byte
  logic [CurveWidth+FracBits-1:0] interp_q;
  logic signed [CurveWidth-1:0]   base_q;
  logic [7:0]                     lbyte_q;
  logic                           sat3_q, lseg3_q;

  // Stage 4: result byte
  logic [7:0] byte_q;

  // Stage 2 combinational
  logic [23:0]             u;
  logic                    sat;
  logic [CurveTableBits:0] idx_lo, idx_hi;

  assign u      = prod_q[38:15];
  assign sat    = |prod_q[ProdWidth-1:39];
  assign idx_lo = {1'b0, u[23:FracBits]};
  assign idx_hi = idx_lo + 1'b1;

  // Stage 3 combinational
  logic signed [CurveWidth:0] diff;
  logic [CurveWidth-1:0]      diff_c;
  logic [23:0]                lq;

  assign diff   = {hi_q[CurveWidth-1], hi_q} - {lo_q[CurveWidth-1], lo_q};
  assign diff_c = diff[CurveWidth] ? '0 : diff[CurveWidth-1:0];
  assign lq     = 24'(linprod_q[34:24]) * 24'(DivHundredMul);

  // Stage 4 combinational
  logic signed [CurveWidth+1:0] v;
  logic [7:0]                   byte_d;

  assign v = {{2{base_q[CurveWidth-1]}}, base_q}
           + $signed({2'b00, interp_q[CurveWidth+FracBits-1:FracBits]});

  always_comb begin
    priority if (sat3_q) begin
      byte_d = ByteMax;
    end else if (lseg3_q) begin
      byte_d = lbyte_q;
    end else if (v <= 0) begin
      byte_d = '0;
    end else if (|v[CurveWidth+1:24]) begin
      byte_d = ByteMax;
    end else begin
      byte_d = v[23:16];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.s1) begin
      prod_q <= ProdWidth'(lin_i) * ProdWidth'(scale_i);
    end
    if (adv_i.s2) begin
      lo_q      <= CurveTab[idx_lo];
      hi_q      <= CurveTab[idx_hi];
      frac_q    <= u[FracBits-1:0];
      linprod_q <= 35'(u[15:0]) * 35'(LinearSlope);
      sat2_q    <= sat;
      lseg2_q   <= !sat && (u <= LinearLimit);
    end
    if (adv_i.s3) begin
      interp_q <= (CurveWidth+FracBits)'(diff_c) * (CurveWidth+FracBits)'(frac_q);
      base_q   <= lo_q;
      lbyte_q  <= 8'(lq[23:19]);
      sat3_q   <= sat2_q;
      lseg3_q  <= lseg2_q;
    end
    if (adv_i.s4) begin
      byte_q <= byte_d;
    end
  end

  assign byte_o = byte_q;

endmodule
